@@ rtl/rcgsp_pkg.sv @@
package rcgsp_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_BITS   = $clog2(SLOTS);
  localparam int DEPTH_BITS = $clog2(SLOTS + 1);
  localparam int GEN_BITS   = 16;
  localparam int REF_BITS   = 16;
  localparam int KEY_BITS   = 64;

  localparam int HIDX_BITS  = 8;
  localparam int HGEN_BITS  = 16;
  localparam int KIND_BITS  = 2;
  localparam int STAT_BITS  = 3;
  localparam int OSLOT_BITS = 6;
  localparam int OGEN_BITS  = 16;

  localparam int IN_DATA_BITS  = 88;
  localparam int OUT_DATA_BITS = 24;

  localparam logic [KIND_BITS-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_GET     = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_LOAD_HIT = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_LOAD_NEW = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_DEC      = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_FREED    = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_REJECT   = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_LIVE     = 3'd6;

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_INC   = 3'd1;
  localparam logic [2:0] OP_DEC   = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_ALLOC = 3'd4;

  typedef struct packed {
    logic [2:0]          op;
    logic [KEY_BITS-1:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic                live;
    logic [GEN_BITS-1:0] gen;
    logic [REF_BITS-1:0] refs;
  } cell_stat_t;

endpackage

@@ rtl/refcounted_generational_slot_pool.sv @@
// Slot pool with key deduplication and generational, reference-counted handles.
// Input channel (in_*): in_tuser holds the kind (load, release, get); in_tdata
// holds the key, the handle index and the handle generation. Result channel
// (out_*): one item per input item, status on out_tuser, slot and generation
// of the returned handle on out_tdata (zero unless the load succeeded).
// Each slot lives in one cell of a row; all cells compare the key at once and
// a one-hot select reads the chosen cell back.
// Steps: match, encode and execute (the update of the cell row), then output;
// a load that takes a new slot also passes a fetch step before output. One item
// is in work at a time, so a new item is accepted only after the last one has
// left the output step.
// The free stack is a 64-entry RAM with registered read.
// Reset (rst_n low, synchronous) empties the pool: all slots dead with
// generation and count zero, free stack empty, no result pending.
// A finished result waits in the output register while out_tready is low;
// the next item is still accepted and runs until its own result is ready,
// then waits for the output register to drain.
module refcounted_generational_slot_pool
  import rcgsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // key, handle_index, handle_generation
  input  logic [KIND_BITS-1:0]     in_tuser,   // kind
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // slot_number, slot_generation_out, pad
  output logic [STAT_BITS-1:0]     out_tuser   // status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_ENC   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [KIND_BITS-1:0] req_kind_r;
  logic [KEY_BITS-1:0]  req_key_r;
  logic [HIDX_BITS-1:0] req_idx_r;
  logic [HGEN_BITS-1:0] req_gen_r;

  logic [SLOTS-1:0]    sel_r, sel_nxt;
  logic [SLOTS-1:0]    match_vec;
  logic [SLOTS-1:0]    cell_en;
  cell_stat_t          stat_vec [SLOTS];
  cell_cmd_t           cmd;

  cell_stat_t          rd_mux;
  logic [IDX_BITS-1:0] enc_idx;
  logic                rd_live_r;
  logic [GEN_BITS-1:0] rd_gen_r;
  logic [REF_BITS-1:0] rd_refs_r;
  logic                hit_any_r;
  logic [IDX_BITS-1:0] hit_idx_r;

  logic [DEPTH_BITS-1:0] free_depth_r, free_depth_nxt;
  logic [DEPTH_BITS-1:0] high_water_r, high_water_nxt;
  logic [IDX_BITS-1:0]   stk_raddr;
  logic [IDX_BITS-1:0]   stk_rdata;
  logic                  push;

  logic [2:0]            op;
  logic [IDX_BITS-1:0]   tgt;
  logic [STAT_BITS-1:0]  ex_status;
  logic [OSLOT_BITS-1:0] ex_slot;
  logic [OGEN_BITS-1:0]  ex_gen;
  logic                  ex_new;
  logic                  rel_ok;

  logic [STAT_BITS-1:0]  res_status_r;
  logic [OSLOT_BITS-1:0] res_slot_r;
  logic [OGEN_BITS-1:0]  res_gen_r;
  logic                  res_new_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_BITS-1:0]  out_status_r;
  logic [OSLOT_BITS-1:0] out_slot_r;
  logic [OGEN_BITS-1:0]  out_gen_r;
  logic                  out_load;

  assign in_tready = (state_r == S_IDLE);
  assign cmd       = '{op: op, key: req_key_r};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cell_en[i] = (op != OP_NOP) && (tgt == IDX_BITS'(i));
    rcgsp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .en    (cell_en[i]),
      .match (match_vec[i]),
      .stat  (stat_vec[i])
    );
  end

  always_comb begin
    rd_mux  = '0;
    enc_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_r[i]) begin
        rd_mux  = rd_mux | stat_vec[i];
        enc_idx = enc_idx | IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    if (state_r == S_MATCH) begin
      for (int i = 0; i < SLOTS; i++) begin
        sel_nxt[i] = (req_kind_r == KIND_LOAD) ? match_vec[i]
                                               : (req_idx_r == HIDX_BITS'(i));
      end
    end else if (state_r == S_EXEC && ex_new) begin
      for (int i = 0; i < SLOTS; i++) begin
        sel_nxt[i] = (tgt == IDX_BITS'(i));
      end
    end
  end

  assign stk_raddr = IDX_BITS'(free_depth_r - DEPTH_BITS'(1));

  rcgsp_ram #(
    .WIDTH (IDX_BITS),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (free_depth_r[IDX_BITS-1:0]),
    .wdata (req_idx_r[IDX_BITS-1:0]),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    op             = OP_NOP;
    tgt            = '0;
    ex_status      = ST_REJECT;
    ex_slot        = '0;
    ex_gen         = '0;
    ex_new         = 1'b0;
    push           = 1'b0;
    free_depth_nxt = free_depth_r;
    high_water_nxt = high_water_r;
    rel_ok = (req_gen_r != '0) && (req_idx_r < HIDX_BITS'(SLOTS)) && rd_live_r;
    if (state_r == S_EXEC) begin
      case (req_kind_r)
        KIND_LOAD: begin
          if (hit_any_r) begin
            op        = OP_INC;
            tgt       = hit_idx_r;
            ex_status = ST_LOAD_HIT;
            ex_slot   = OSLOT_BITS'(hit_idx_r);
            ex_gen    = OGEN_BITS'(rd_gen_r);
          end else if (free_depth_r != '0) begin
            op             = OP_ALLOC;
            tgt            = stk_rdata;
            ex_status      = ST_LOAD_NEW;
            ex_slot        = OSLOT_BITS'(stk_rdata);
            ex_new         = 1'b1;
            free_depth_nxt = free_depth_r - DEPTH_BITS'(1);
          end else if (high_water_r < DEPTH_BITS'(SLOTS)) begin
            op             = OP_ALLOC;
            tgt            = high_water_r[IDX_BITS-1:0];
            ex_status      = ST_LOAD_NEW;
            ex_slot        = OSLOT_BITS'(high_water_r[IDX_BITS-1:0]);
            ex_new         = 1'b1;
            high_water_nxt = high_water_r + DEPTH_BITS'(1);
          end else begin
            ex_status = ST_FULL;
          end
        end
        KIND_RELEASE: begin
          tgt = req_idx_r[IDX_BITS-1:0];
          if (rel_ok && rd_gen_r == GEN_BITS'(req_gen_r)) begin
            if (rd_refs_r > REF_BITS'(1)) begin
              op        = OP_DEC;
              ex_status = ST_DEC;
            end else begin
              op        = OP_FREE;
              ex_status = ST_FREED;
              if (free_depth_r < DEPTH_BITS'(SLOTS)) begin
                push           = 1'b1;
                free_depth_nxt = free_depth_r + DEPTH_BITS'(1);
              end
            end
          end
        end
        KIND_GET: begin
          ex_status = rel_ok ? ST_LIVE : ST_REJECT;
        end
        default: begin
          ex_status = ST_REJECT;
        end
      endcase
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_ENC;
      S_ENC:   state_nxt = S_EXEC;
      S_EXEC:  state_nxt = ex_new ? S_FETCH : S_OUT;
      S_FETCH: state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_depth_r <= '0;
      high_water_r <= '0;
      out_valid_r  <= 1'b0;
      sel_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      free_depth_r <= free_depth_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
      sel_r        <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_kind_r <= in_tuser;
      req_key_r  <= in_tdata[KEY_BITS-1:0];
      req_idx_r  <= in_tdata[71:64];
      req_gen_r  <= in_tdata[87:72];
    end
    rd_live_r <= rd_mux.live;
    rd_gen_r  <= rd_mux.gen;
    rd_refs_r <= rd_mux.refs;
    if (state_r == S_ENC) begin
      hit_any_r <= |sel_r;
      hit_idx_r <= enc_idx;
    end
    if (state_r == S_EXEC) begin
      res_status_r <= ex_status;
      res_slot_r   <= ex_slot;
      res_gen_r    <= ex_gen;
      res_new_r    <= ex_new;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_gen_r    <= res_new_r ? OGEN_BITS'(rd_gen_r) : res_gen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_gen_r, out_slot_r};

endmodule

@@ rtl/rcgsp_ram.sv @@
module rcgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rcgsp_cell.sv @@
module rcgsp_cell
  import rcgsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       en,
  output logic       match,
  output cell_stat_t stat
);

  logic                live_r, live_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;
  logic [REF_BITS-1:0] refs_r, refs_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [GEN_BITS-1:0] gen_inc;

  assign gen_inc = gen_r + GEN_BITS'(1);

  always_comb begin
    live_nxt = live_r;
    gen_nxt  = gen_r;
    refs_nxt = refs_r;
    if (en) begin
      case (cmd.op)
        OP_INC: begin
          if (refs_r != '1) begin
            refs_nxt = refs_r + REF_BITS'(1);
          end
        end
        OP_DEC: begin
          refs_nxt = refs_r - REF_BITS'(1);
        end
        OP_FREE: begin
          live_nxt = 1'b0;
          refs_nxt = '0;
          gen_nxt  = gen_inc;
        end
        OP_ALLOC: begin
          live_nxt = 1'b1;
          refs_nxt = REF_BITS'(1);
          gen_nxt  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      gen_r  <= '0;
      refs_r <= '0;
    end else begin
      live_r <= live_nxt;
      gen_r  <= gen_nxt;
      refs_r <= refs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && cmd.op == OP_ALLOC) begin
      key_r <= cmd.key;
    end
  end

  assign match = live_r && (key_r == cmd.key);
  assign stat  = '{live: live_r, gen: gen_r, refs: refs_r};

endmodule

@@ rtl/rcgsp_chk.sv @@
module rcgsp_chk
  import rcgsp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [IN_DATA_BITS-1:0]  in_tdata,
  input logic [KIND_BITS-1:0]     in_tuser,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [STAT_BITS-1:0]     out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 3'd7)
    else $error("undefined status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_LOAD_HIT && out_tuser != ST_LOAD_NEW
      |-> out_tdata == '0)
    else $error("nonzero handle on a result that is not a load");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_LOAD_HIT || out_tuser == ST_LOAD_NEW)
      |-> out_tdata[21:6] != '0)
    else $error("load returned generation zero");

endmodule

bind refcounted_generational_slot_pool rcgsp_chk u_rcgsp_chk (.*);

@@ verif/tb_refcounted_generational_slot_pool.sv @@
module tb_refcounted_generational_slot_pool;
  import rcgsp_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_BAD = 2'd3;
  localparam int KEY_POOL     = 80;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 100_000;

  typedef struct {
    logic [STAT_BITS-1:0]  status;
    logic [OSLOT_BITS-1:0] slot;
    logic [OGEN_BITS-1:0]  gen;
  } pool_result_t;

  typedef struct {
    logic [HIDX_BITS-1:0] idx;
    logic [HGEN_BITS-1:0] gen;
  } handle_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [KIND_BITS-1:0]     in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [STAT_BITS-1:0]     out_tuser;

  refcounted_generational_slot_pool u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool model state
  logic [KEY_BITS-1:0]   slot_key  [SLOTS];
  bit                    slot_live [SLOTS];
  logic [GEN_BITS-1:0]   slot_gen  [SLOTS];
  logic [REF_BITS-1:0]   slot_refs [SLOTS];
  logic [IDX_BITS-1:0]   free_lifo [SLOTS];
  int                    lifo_depth;
  int                    next_unused;

  pool_result_t          pending_results[$];
  handle_t               held_handles[$];
  logic [KEY_BITS-1:0]   key_pool[KEY_POOL];

  int  in_idle_pct;
  int  out_idle_pct;
  bit  stall_req;
  bit  stall_seen;
  int  stall_left;
  int  cycle_count;
  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  full_count;
  int  sat_hits;
  int  gen_wraps;
  int  fresh_count;
  pool_result_t want;

  function automatic pool_result_t pool_predict(input logic [KIND_BITS-1:0] kind,
                                                input logic [KEY_BITS-1:0] key,
                                                input logic [HIDX_BITS-1:0] idx,
                                                input logic [HGEN_BITS-1:0] hgen);
    pool_result_t r;
    int hit;
    int s;
    logic [GEN_BITS-1:0] g;
    r.status = ST_REJECT;
    r.slot = '0;
    r.gen = '0;
    hit = -1;
    s = -1;
    case (kind)
      KIND_LOAD: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
        if (hit >= 0) begin
          if (slot_refs[hit] != '1) slot_refs[hit]++;
          else sat_hits++;
          r.status = ST_LOAD_HIT;
          r.slot = hit[OSLOT_BITS-1:0];
          r.gen = slot_gen[hit];
        end else begin
          if (lifo_depth > 0) begin
            lifo_depth--;
            s = free_lifo[lifo_depth];
          end else if (next_unused < SLOTS) begin
            s = next_unused;
            next_unused++;
          end
          if (s < 0) begin
            r.status = ST_FULL;
            full_count++;
          end else begin
            g = slot_gen[s] + 1'b1;
            if (g == '0) g = GEN_BITS'(1);
            slot_gen[s] = g;
            slot_live[s] = 1'b1;
            slot_refs[s] = REF_BITS'(1);
            slot_key[s] = key;
            r.status = ST_LOAD_NEW;
            r.slot = s[OSLOT_BITS-1:0];
            r.gen = g;
          end
        end
      end
      KIND_RELEASE: begin
        if (hgen != 0 && idx < SLOTS && slot_live[idx] && slot_gen[idx] == hgen) begin
          if (slot_refs[idx] != 0) slot_refs[idx]--;
          if (slot_refs[idx] != 0) begin
            r.status = ST_DEC;
          end else begin
            slot_live[idx] = 1'b0;
            slot_gen[idx] = slot_gen[idx] + 1'b1;
            if (slot_gen[idx] == '0) gen_wraps++;
            if (lifo_depth < SLOTS) begin
              free_lifo[lifo_depth] = idx[IDX_BITS-1:0];
              lifo_depth++;
            end
            r.status = ST_FREED;
          end
        end
      end
      KIND_GET: begin
        if (hgen != 0 && idx < SLOTS && slot_live[idx]) r.status = ST_LIVE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] fresh_key();
    fresh_count++;
    return {16'hF7E5, 16'h0, fresh_count[31:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 20)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  task automatic send_item(input logic [KIND_BITS-1:0] kind, input logic [KEY_BITS-1:0] key,
                           input logic [HIDX_BITS-1:0] idx, input logic [HGEN_BITS-1:0] hgen,
                           output pool_result_t res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {hgen, idx, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = pool_predict(kind, key, idx, hgen);
    pending_results.insert(pending_results.size(), res);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, status", out_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tdata[5:0] !== want.slot) report_mismatch("slot", out_tdata[5:0], want.slot);
        if (out_tdata[21:6] !== want.gen) report_mismatch("generation", out_tdata[21:6], want.gen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    pool_result_t a;
    pool_result_t b;
    pool_result_t c;
    pool_result_t r;
    in_idle_pct = 31;
    out_idle_pct = 74;
    send_item(KIND_LOAD, '0, '0, '0, a);
    send_item(KIND_LOAD, '1, '1, '1, b);
    send_item(KIND_LOAD, '0, '0, '0, r);
    send_item(KIND_GET, '0, a.slot, a.gen, r);
    send_item(KIND_GET, '0, a.slot, '0, r);
    send_item(KIND_GET, '1, 8'd255, 16'hFFFF, r);
    send_item(KIND_GET, '0, 8'd64, 16'd1, r);
    send_item(KIND_GET, '0, 8'd63, 16'd1, r);
    send_item(KIND_RELEASE, '0, b.slot, b.gen + 1'b1, r);
    send_item(KIND_RELEASE, '0, a.slot, '0, r);
    send_item(KIND_RELEASE, '0, 8'd200, a.gen, r);
    send_item(KIND_RELEASE, '0, a.slot, a.gen, r);
    send_item(KIND_RELEASE, '0, a.slot, a.gen, r);
    send_item(KIND_RELEASE, '0, a.slot, a.gen, r);
    send_item(KIND_GET, '0, a.slot, a.gen, r);
    send_item(KIND_BAD, '1, 8'd255, 16'hFFFF, r);
    send_item(KIND_LOAD, 64'h8000_0000_0000_0001, '0, '0, c);
    send_item(KIND_GET, '0, a.slot, a.gen, r);
    send_item(KIND_RELEASE, '0, b.slot, b.gen, r);
    send_item(KIND_RELEASE, '0, c.slot, c.gen, r);
    wait_drained();
  endtask

  // repeated hits on one key raise its count
  task automatic test_repeated_hits();
    pool_result_t r;
    logic [KEY_BITS-1:0] k;
    in_idle_pct = 0;
    out_idle_pct = 0;
    k = {$urandom, $urandom};
    repeat (40) send_item(KIND_LOAD, k, '0, '0, r);
    send_item(KIND_RELEASE, '0, r.slot, r.gen, r);
    wait_drained();
  endtask

  // cycle one slot through alloc/free so its generation keeps advancing
  task automatic test_slot_reuse();
    pool_result_t r;
    pool_result_t stale;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (100) begin
      send_item(KIND_LOAD, fresh_key(), '0, '0, r);
      send_item(KIND_RELEASE, '0, r.slot, r.gen, stale);
    end
    send_item(KIND_LOAD, fresh_key(), '0, '0, r);
    send_item(KIND_RELEASE, '0, r.slot, 16'hFFFF, stale);
    send_item(KIND_RELEASE, '0, r.slot, r.gen, stale);
    wait_drained();
  endtask

  task automatic test_table_full();
    pool_result_t r;
    pool_result_t extra;
    handle_t h;
    handle_t owned[$];
    logic [KEY_BITS-1:0] first_key;
    int sel;
    in_idle_pct = 74;
    out_idle_pct = 31;
    first_key = fresh_key();
    send_item(KIND_LOAD, first_key, '0, '0, r);
    while (r.status == ST_LOAD_NEW) begin
      h.idx = r.slot;
      h.gen = r.gen;
      owned.insert(owned.size(), h);
      send_item(KIND_LOAD, fresh_key(), '0, '0, r);
    end
    send_item(KIND_LOAD, first_key, '0, '0, extra);
    send_item(KIND_LOAD, fresh_key(), '1, '1, r);
    send_item(KIND_RELEASE, '0, extra.slot, extra.gen, r);
    while (owned.size() != 0) begin
      sel = $urandom_range(owned.size() - 1);
      h = owned[sel];
      owned.delete(sel);
      send_item(KIND_RELEASE, '0, h.idx, h.gen, r);
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    pool_result_t r;
    handle_t h;
    in_idle_pct = 0;
    out_idle_pct = 0;
    stall_req <= ~stall_req;
    repeat (6) begin
      send_item(KIND_LOAD, key_pool[$urandom_range(KEY_POOL - 1)], '0, '0, r);
      h.idx = r.slot;
      h.gen = r.gen;
      send_item(KIND_GET, '0, h.idx, h.gen, r);
      send_item(KIND_RELEASE, '0, h.idx, h.gen, r);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int in_pct, input int out_pct);
    pool_result_t r;
    handle_t h;
    int pick;
    int sel;
    logic [KEY_BITS-1:0] k;
    logic [KIND_BITS-1:0] kind;
    logic [HIDX_BITS-1:0] idx;
    logic [HGEN_BITS-1:0] hgen;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) k = fresh_key();
        else k = key_pool[$urandom_range(KEY_POOL - 1)];
        send_item(KIND_LOAD, k, HIDX_BITS'($urandom), HGEN_BITS'($urandom), r);
        if (r.status == ST_LOAD_HIT || r.status == ST_LOAD_NEW) begin
          h.idx = r.slot;
          h.gen = r.gen;
          held_handles.insert(held_handles.size(), h);
        end
      end else if (pick < 75 && held_handles.size() != 0) begin
        sel = $urandom_range(held_handles.size() - 1);
        h = held_handles[sel];
        held_handles.delete(sel);
        send_item(KIND_RELEASE, {$urandom, $urandom}, h.idx, h.gen, r);
      end else if (pick < 85 && held_handles.size() != 0) begin
        h = held_handles[$urandom_range(held_handles.size() - 1)];
        send_item(KIND_GET, {$urandom, $urandom}, h.idx, h.gen, r);
      end else begin
        kind = KIND_BITS'($urandom_range(3, 1));
        idx = HIDX_BITS'($urandom);
        hgen = HGEN_BITS'($urandom);
        if (held_handles.size() != 0 && $urandom_range(1) == 0) begin
          h = held_handles[$urandom_range(held_handles.size() - 1)];
          idx = h.idx;
          hgen = h.gen ^ (16'd1 << $urandom_range(15));
        end
        if ($urandom_range(7) == 0) hgen = '0;
        send_item(kind, {$urandom, $urandom}, idx, hgen, r);
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
      slot_refs[i] = '0;
    end
    lifo_depth = 0;
    next_unused = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_repeated_hits();
    test_slot_reuse();
    test_table_full();
    test_backpressure();
    test_random_traffic(460, 31, 74);
    test_random_traffic(460, 74, 31);
    test_random_traffic(460, 0, 0);

    repeat (20) @(posedge clk);
    $display("%0d items, %0d results checked, %0d mismatches", items_sent, results_checked,
             mismatches);
    $display("table full %0d times, %0d hits at max count, %0d generation wraps, stalled output",
             full_count, sat_hits, gen_wraps);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rcgsp_pkg.sv
rtl/rcgsp_ram.sv
rtl/rcgsp_cell.sv
rtl/refcounted_generational_slot_pool.sv
rtl/rcgsp_chk.sv
verif/tb_refcounted_generational_slot_pool.sv
